[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers that reduce to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle assertion failed");
`else
`define ASSERT_SAME(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[sv/hnm_pkg.sv]
// ----------------------------------------------------------------------------
// hnm_pkg
// Shared types and constants of the height to normal map block.
// ----------------------------------------------------------------------------
`default_nettype none

package hnm_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INTENSITY    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_STRENGTH     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_TEXEL_STEP   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_PLANE_X      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_PLANE_Y      = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_MASK_ENABLE  = 3'd7;

   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_COMPUTE = 1'b1;

   localparam int NUM_W = 55;
   localparam int DEN_W = 32;

   typedef struct packed {
      logic       capture;
      logic       write_store;
      logic       setup;
      logic       row;
      logic [1:0] sample;
      logic       read_en;
      logic [1:0] tap;
      logic       acc_en;
      logic       mul1;
      logic       mul2;
      logic       axis;
      logic       slope_m1;
      logic       slope_m2;
      logic       slope_start;
      logic       slope_save;
      logic       sq1;
      logic       sq2;
      logic       sqrt_step;
      logic [1:0] chan;
      logic       enc_start;
      logic       enc_save;
      logic       out_load;
   } hnm_cmd_type;

   typedef struct packed {
      logic div_done;
      logic out_free;
   } hnm_status_type;

endpackage

`default_nettype wire

[sv/height_to_normal_map.sv]
// ----------------------------------------------------------------------------
// height_to_normal_map
// Turns a stored height image into tangent-space normals, one pixel per beat.
// ----------------------------------------------------------------------------
//   channel | direction | handshake         | payload
//   req     | in        | req_valid/stall   | command, pixel, height, mask
//   rsp     | out       | rsp_valid/stall   | red, green, blue, out_x, out_y
//   csr     | in        | csr_write         | csr_index, csr_wdata
//
// A load beat captures the request, then writes both stores if the pixel
// lies inside the image. A compute beat makes sixteen texel reads over one
// store port, then five passes through the shared 55-step divider and a
// 32-step square root, and loads the output once free. Reset is synchronous
// and restores the register defaults; the stores are not cleared. A
// finished result waits in the output register while the next beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module height_to_normal_map #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write,
   input  wire logic [hnm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [hnm_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic                           req_command,
   input  wire logic [7:0]                     req_pixel_x,
   input  wire logic [7:0]                     req_pixel_y,
   input  wire logic [15:0]                    req_height_value,
   input  wire logic [15:0]                    req_mask_value,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [7:0]                          rsp_normal_red,
   output logic [7:0]                          rsp_normal_green,
   output logic [7:0]                          rsp_normal_blue,
   output logic [7:0]                          rsp_out_x,
   output logic [7:0]                          rsp_out_y
);
   import hnm_pkg::*;

   hnm_cmd_type    cmd;
   hnm_status_type status;

   hnm_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .status      (status),
      .cmd         (cmd)
   );

   hnm_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_pixel_x      (req_pixel_x),
      .req_pixel_y      (req_pixel_y),
      .req_height_value (req_height_value),
      .req_mask_value   (req_mask_value),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_normal_red   (rsp_normal_red),
      .rsp_normal_green (rsp_normal_green),
      .rsp_normal_blue  (rsp_normal_blue),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .cmd              (cmd),
      .status           (status)
   );

   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `ASSERT_SAME(a_out_load_free, clock, reset, cmd.out_load, !rsp_valid || !rsp_stall)
   `ASSERT_NEXT(a_load_writes, clock, reset, req_valid && !req_stall && (req_command == CMD_LOAD), cmd.write_store)

endmodule

`default_nettype wire

[sv/hnm_div.sv]
// ----------------------------------------------------------------------------
// hnm_div
// Restoring divider, one quotient bit per cycle, shared by slopes and encode.
// ----------------------------------------------------------------------------
`default_nettype none

module hnm_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [hnm_pkg::NUM_W-1:0] numer,
   input  wire logic [hnm_pkg::DEN_W-1:0] denom,
   output logic                           done,
   output logic [hnm_pkg::NUM_W-1:0]      quot
);
   import hnm_pkg::*;

   localparam int CNT_W = $clog2(NUM_W);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic             ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      ge      = trial >= {1'b0, den_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = numer;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
         quo_in = {quo_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         den_ff <= denom;
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

`default_nettype wire

[sv/hnm_ctrl.sv]
// ----------------------------------------------------------------------------
// hnm_ctrl
// Sequencer that steps the datapath through loads and normal computations.
// ----------------------------------------------------------------------------
`default_nettype none

module hnm_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    req_command,
   output logic                         req_stall,
   input  wire hnm_pkg::hnm_status_type status,
   output hnm_pkg::hnm_cmd_type         cmd
);
   import hnm_pkg::*;

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_LOAD  = 5'd1;
   localparam logic [4:0] S_POS   = 5'd2;
   localparam logic [4:0] S_ROW   = 5'd3;
   localparam logic [4:0] S_RD    = 5'd4;
   localparam logic [4:0] S_RDL   = 5'd5;
   localparam logic [4:0] S_MUL1  = 5'd6;
   localparam logic [4:0] S_MUL2  = 5'd7;
   localparam logic [4:0] S_SM1   = 5'd8;
   localparam logic [4:0] S_SM2   = 5'd9;
   localparam logic [4:0] S_SDIV  = 5'd10;
   localparam logic [4:0] S_SWAIT = 5'd11;
   localparam logic [4:0] S_SQ1   = 5'd12;
   localparam logic [4:0] S_SQ2   = 5'd13;
   localparam logic [4:0] S_SQRT  = 5'd14;
   localparam logic [4:0] S_EST   = 5'd15;
   localparam logic [4:0] S_EWAIT = 5'd16;
   localparam logic [4:0] S_DONE  = 5'd17;

   logic [4:0] state_ff, state_in;
   logic [1:0] sample_ff, sample_in;
   logic [1:0] tap_ff, tap_in;
   logic       axis_ff, axis_in;
   logic [4:0] step_ff, step_in;
   logic [1:0] chan_ff, chan_in;

   always_comb begin
      state_in   = state_ff;
      sample_in  = sample_ff;
      tap_in     = tap_ff;
      axis_in    = axis_ff;
      step_in    = step_ff;
      chan_in    = chan_ff;
      cmd        = '0;
      cmd.sample = sample_ff;
      cmd.tap    = tap_ff;
      cmd.axis   = axis_ff;
      cmd.chan   = chan_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               sample_in   = '0;
               state_in    = (req_command == CMD_COMPUTE) ? S_POS : S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.write_store = 1'b1;
            state_in        = S_IDLE;
         end
         S_POS: begin
            cmd.setup = 1'b1;
            state_in  = S_ROW;
         end
         S_ROW: begin
            cmd.row  = 1'b1;
            tap_in   = '0;
            state_in = S_RD;
         end
         S_RD: begin
            cmd.read_en = 1'b1;
            cmd.acc_en  = (tap_ff != 2'd0);
            tap_in      = tap_ff + 1'b1;
            if (tap_ff == 2'd3) begin
               state_in = S_RDL;
            end
         end
         S_RDL: begin
            cmd.acc_en = 1'b1;
            state_in   = S_MUL1;
         end
         S_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul2  = 1'b1;
            sample_in = sample_ff + 1'b1;
            if (sample_ff == 2'd3) begin
               axis_in  = 1'b0;
               state_in = S_SM1;
            end else begin
               state_in = S_POS;
            end
         end
         S_SM1: begin
            cmd.slope_m1 = 1'b1;
            state_in     = S_SM2;
         end
         S_SM2: begin
            cmd.slope_m2 = 1'b1;
            state_in     = S_SDIV;
         end
         S_SDIV: begin
            cmd.slope_start = 1'b1;
            state_in        = S_SWAIT;
         end
         S_SWAIT: begin
            if (status.div_done) begin
               cmd.slope_save = 1'b1;
               axis_in        = 1'b1;
               state_in       = axis_ff ? S_SQ1 : S_SM1;
            end
         end
         S_SQ1: begin
            cmd.sq1  = 1'b1;
            state_in = S_SQ2;
         end
         S_SQ2: begin
            cmd.sq2  = 1'b1;
            step_in  = '0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            step_in       = step_ff + 1'b1;
            if (step_ff == 5'd31) begin
               chan_in  = '0;
               state_in = S_EST;
            end
         end
         S_EST: begin
            cmd.enc_start = 1'b1;
            state_in      = S_EWAIT;
         end
         S_EWAIT: begin
            if (status.div_done) begin
               cmd.enc_save = 1'b1;
               chan_in      = chan_ff + 1'b1;
               state_in     = (chan_ff == 2'd2) ? S_DONE : S_EST;
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         sample_ff <= '0;
         tap_ff    <= '0;
         axis_ff   <= 1'b0;
         step_ff   <= '0;
         chan_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         sample_ff <= sample_in;
         tap_ff    <= tap_in;
         axis_ff   <= axis_in;
         step_ff   <= step_in;
         chan_ff   <= chan_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

`default_nettype wire

[sv/hnm_datapath.sv]
// ----------------------------------------------------------------------------
// hnm_datapath
// Texel stores, bilinear sampling, slope, root and encode arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module hnm_datapath #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write,
   input  wire logic [hnm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [hnm_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic [7:0]                     req_pixel_x,
   input  wire logic [7:0]                     req_pixel_y,
   input  wire logic [15:0]                    req_height_value,
   input  wire logic [15:0]                    req_mask_value,
   input  wire logic                           rsp_stall,
   output logic                                rsp_valid,
   output logic [7:0]                          rsp_normal_red,
   output logic [7:0]                          rsp_normal_green,
   output logic [7:0]                          rsp_normal_blue,
   output logic [7:0]                          rsp_out_x,
   output logic [7:0]                          rsp_out_y,
   input  wire hnm_pkg::hnm_cmd_type           cmd,
   output hnm_pkg::hnm_status_type             status
);
   import hnm_pkg::*;

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int DIM_W = 13;
   localparam int POS_W = 19;
   localparam logic [29:0] SLOPE_MAX = 30'h3FFF_FFFF;
   localparam logic [24:0] ENC_MID   = 25'd8355840;

   typedef struct packed {
      logic [DIM_W-1:0] i0;
      logic [DIM_W-1:0] i1;
      logic [4:0]       al;
   } axis_type;

   function automatic logic signed [POS_W-1:0] place_f(
      input logic [7:0]              c,
      input logic signed [POS_W-1:0] off,
      input logic [DIM_W-1:0]        n
   );
      logic signed [POS_W-1:0] v;
      logic signed [POS_W-1:0] top;
      v   = $signed({7'd0, c, 4'd0}) + 19'sd8 + off;
      top = $signed({2'd0, n, 4'd0});
      if (v < 0) begin
         v = '0;
      end
      if (v > top) begin
         v = top;
      end
      return v - 19'sd8;
   endfunction

   function automatic axis_type axis_f(
      input logic signed [POS_W-1:0] p,
      input logic [DIM_W-1:0]        n
   );
      axis_type                r;
      logic signed [POS_W-1:0] fl;
      logic signed [POS_W-1:0] d;
      logic [DIM_W-1:0]        a;
      logic [DIM_W-1:0]        nm1;
      nm1 = n - 1'b1;
      fl  = (p >= 0) ? (p >>> 4) : -19'sd1;
      if (fl < 0) begin
         a = '0;
      end else if (fl > $signed({6'd0, nm1})) begin
         a = nm1;
      end else begin
         a = fl[DIM_W-1:0];
      end
      r.i0 = a;
      r.i1 = (a >= nm1) ? nm1 : a + 1'b1;
      d    = p - $signed({2'd0, a, 4'd0});
      if (d < 0) begin
         r.al = 5'd0;
      end else if (d > 19'sd16) begin
         r.al = 5'd16;
      end else begin
         r.al = d[4:0];
      end
      return r;
   endfunction

   logic [8:0]         width_ff, height_ff;
   logic signed [15:0] inten_ff;
   logic [11:0]        strength_ff;
   logic [7:0]         step_ff;
   logic [15:0]        plane_x_ff, plane_y_ff;
   logic               mask_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= 9'd256;
         height_ff   <= 9'd256;
         inten_ff    <= 16'sd256;
         strength_ff <= 12'd256;
         step_ff     <= 8'd16;
         plane_x_ff  <= 16'd100;
         plane_y_ff  <= 16'd100;
         mask_en_ff  <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            REG_IMAGE_WIDTH:  width_ff    <= csr_wdata[8:0];
            REG_IMAGE_HEIGHT: height_ff   <= csr_wdata[8:0];
            REG_INTENSITY:    inten_ff    <= $signed(csr_wdata);
            REG_STRENGTH:     strength_ff <= csr_wdata[11:0];
            REG_TEXEL_STEP:   step_ff     <= csr_wdata[7:0];
            REG_PLANE_X:      plane_x_ff  <= csr_wdata;
            REG_PLANE_Y:      plane_y_ff  <= csr_wdata;
            REG_MASK_ENABLE:  mask_en_ff  <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   logic [DIM_W-1:0] w_cl, h_cl;
   logic [7:0]       ts_cl;
   logic [15:0]      psx, psy;

   always_comb begin
      if (width_ff == 9'd0) begin
         w_cl = DIM_W'(1);
      end else if ({4'd0, width_ff} > DIM_W'(MAX_WIDTH)) begin
         w_cl = DIM_W'(MAX_WIDTH);
      end else begin
         w_cl = {4'd0, width_ff};
      end
      if (height_ff == 9'd0) begin
         h_cl = DIM_W'(1);
      end else if ({4'd0, height_ff} > DIM_W'(MAX_HEIGHT)) begin
         h_cl = DIM_W'(MAX_HEIGHT);
      end else begin
         h_cl = {4'd0, height_ff};
      end
      ts_cl = (step_ff < 8'd4) ? 8'd4 : step_ff;
      psx   = (plane_x_ff == 16'd0) ? 16'd1 : plane_x_ff;
      psy   = (plane_y_ff == 16'd0) ? 16'd1 : plane_y_ff;
   end

   logic [7:0]  px_ff, py_ff;
   logic [15:0] hv_ff, mv_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         px_ff <= req_pixel_x;
         py_ff <= req_pixel_y;
         hv_ff <= req_height_value;
         mv_ff <= req_mask_value;
      end
   end

   logic [2*DIM_W-1:0] load_prod;
   logic [AW-1:0]      waddr;
   logic               load_ok;

   assign load_prod = {18'd0, py_ff} * {{DIM_W{1'b0}}, w_cl};
   assign waddr     = AW'(load_prod + {18'd0, px_ff});
   assign load_ok   = ({5'd0, px_ff} < w_cl) && ({5'd0, py_ff} < h_cl);

   logic signed [POS_W-1:0] st_pos, st_neg, cx, cy, xs, ys;
   axis_type                xa, ya;

   always_comb begin
      st_pos = $signed({11'd0, ts_cl});
      st_neg = -st_pos;
      cx     = place_f(px_ff, '0, w_cl);
      cy     = place_f(py_ff, '0, h_cl);
      case (cmd.sample)
         2'd0: begin
            xs = place_f(px_ff, st_pos, w_cl);
            ys = cy;
         end
         2'd1: begin
            xs = place_f(px_ff, st_neg, w_cl);
            ys = cy;
         end
         2'd2: begin
            xs = cx;
            ys = place_f(py_ff, st_pos, h_cl);
         end
         default: begin
            xs = cx;
            ys = place_f(py_ff, st_neg, h_cl);
         end
      endcase
      xa = axis_f(xs, w_cl);
      ya = axis_f(ys, h_cl);
   end

   axis_type xa_ff, ya_ff;
   logic [AW-1:0] row0_ff, row1_ff;
   logic [2*DIM_W-1:0] row0_prod, row1_prod;

   assign row0_prod = {{DIM_W{1'b0}}, ya_ff.i0} * {{DIM_W{1'b0}}, w_cl};
   assign row1_prod = {{DIM_W{1'b0}}, ya_ff.i1} * {{DIM_W{1'b0}}, w_cl};

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         xa_ff <= xa;
         ya_ff <= ya;
      end
      if (cmd.row) begin
         row0_ff <= AW'(row0_prod);
         row1_ff <= AW'(row1_prod);
      end
   end

   logic [AW-1:0] raddr;
   logic [4:0]    wx, wy;
   logic [9:0]    wprod;

   always_comb begin
      case (cmd.tap)
         2'd0: begin
            raddr = AW'(row0_ff + AW'(xa_ff.i0));
            wx    = 5'd16 - xa_ff.al;
            wy    = 5'd16 - ya_ff.al;
         end
         2'd1: begin
            raddr = AW'(row0_ff + AW'(xa_ff.i1));
            wx    = xa_ff.al;
            wy    = 5'd16 - ya_ff.al;
         end
         2'd2: begin
            raddr = AW'(row1_ff + AW'(xa_ff.i0));
            wx    = 5'd16 - xa_ff.al;
            wy    = ya_ff.al;
         end
         default: begin
            raddr = AW'(row1_ff + AW'(xa_ff.i1));
            wx    = xa_ff.al;
            wy    = ya_ff.al;
         end
      endcase
      wprod = {5'd0, wx} * {5'd0, wy};
   end

   logic [15:0] height_mem [DEPTH];
   logic [15:0] mask_mem [DEPTH];
   logic [15:0] hq_ff, mq_ff;
   logic [8:0]  wgt_ff;

   always_ff @(posedge clock) begin
      if (cmd.write_store && load_ok) begin
         height_mem[waddr] <= hv_ff;
      end
      if (cmd.read_en) begin
         hq_ff <= height_mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_store && load_ok) begin
         mask_mem[waddr] <= mv_ff;
      end
      if (cmd.read_en) begin
         mq_ff <= mask_mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read_en) begin
         wgt_ff <= wprod[8:0];
      end
   end

   logic [23:0] hacc_ff, macc_ff;
   logic [24:0] hprod, mprod, hsum, msum;

   assign hprod = {9'd0, hq_ff} * {16'd0, wgt_ff};
   assign mprod = {9'd0, mq_ff} * {16'd0, wgt_ff};
   assign hsum  = {1'b0, hacc_ff} + 25'd128;
   assign msum  = {1'b0, macc_ff} + 25'd128;

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         hacc_ff <= '0;
         macc_ff <= '0;
      end else if (cmd.acc_en) begin
         hacc_ff <= hacc_ff + hprod[23:0];
         macc_ff <= macc_ff + mprod[23:0];
      end
   end

   logic signed [32:0] p1_ff;
   logic [16:0]        om_ff;
   logic signed [50:0] p2;
   logic signed [26:0] ht;
   logic signed [27:0] dpos_ff, dx_ff, dy_ff, dnew;

   assign p2   = p1_ff * $signed({34'd0, om_ff});
   assign ht   = p2[50:24];
   assign dnew = dpos_ff - 28'(ht);

   always_ff @(posedge clock) begin
      if (cmd.mul1) begin
         p1_ff <= $signed({17'd0, hsum[23:8]}) * 33'(inten_ff);
         om_ff <= mask_en_ff ? 17'h10000 - {1'b0, msum[23:8]} : 17'h10000;
      end
      if (cmd.mul2) begin
         if (!cmd.sample[0]) begin
            dpos_ff <= 28'(ht);
         end else if (!cmd.sample[1]) begin
            dx_ff <= dnew;
         end else begin
            dy_ff <= dnew;
         end
      end
   end

   logic signed [27:0] dsel;
   logic [27:0]        dmag;
   logic [DIM_W-1:0]   nsel;
   logic [15:0]        pssel;
   logic [39:0]        m1_ff;
   logic [52:0]        m2_ff;
   logic [28:0]        den_ff;
   logic               sneg_ff;
   logic [23:0]        tsps;

   always_comb begin
      dsel  = cmd.axis ? dy_ff : dx_ff;
      dmag  = dsel[27] ? 28'(-dsel) : 28'(dsel);
      nsel  = cmd.axis ? h_cl : w_cl;
      pssel = cmd.axis ? psy : psx;
      tsps  = {16'd0, ts_cl} * {8'd0, pssel};
   end

   always_ff @(posedge clock) begin
      if (cmd.slope_m1) begin
         m1_ff   <= {12'd0, dmag} * {28'd0, strength_ff};
         den_ff  <= {tsps, 5'd0};
         sneg_ff <= dsel[27];
      end
      if (cmd.slope_m2) begin
         m2_ff <= {13'd0, m1_ff} * {40'd0, nsel};
      end
   end

   logic                    div_start, div_done;
   logic [NUM_W-1:0]        div_numer, div_quot;
   logic [DEN_W-1:0]        div_denom;
   logic [29:0]             a_mag_ff, b_mag_ff, sat;
   logic                    a_neg_ff, b_neg_ff;
   logic [63:0]             v_ff, r_ff, bit_ff, rb;
   logic [59:0]             a2_ff;
   logic [30:0]             emag;
   logic [38:0]             e255;

   assign sat = (div_quot > NUM_W'(SLOPE_MAX)) ? SLOPE_MAX : div_quot[29:0];

   always_comb begin
      case (cmd.chan)
         2'd0:    emag = {1'b0, a_mag_ff};
         2'd1:    emag = {1'b0, b_mag_ff};
         default: emag = 31'd65536;
      endcase
      e255      = {emag, 8'd0} - {8'd0, emag};
      div_start = cmd.slope_start || cmd.enc_start;
      div_numer = cmd.enc_start ? {1'b0, e255, 15'd0} : {2'd0, m2_ff};
      div_denom = cmd.enc_start ? r_ff[31:0] : {3'd0, den_ff};
   end

   hnm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (div_denom),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign rb = r_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (cmd.slope_save) begin
         if (cmd.axis) begin
            b_mag_ff <= sat;
            b_neg_ff <= sneg_ff;
         end else begin
            a_mag_ff <= sat;
            a_neg_ff <= sneg_ff;
         end
      end
      if (cmd.sq1) begin
         a2_ff <= {30'd0, a_mag_ff} * {30'd0, a_mag_ff};
      end
      if (cmd.sq2) begin
         v_ff   <= 64'h1_0000_0000 + {4'd0, a2_ff}
                   + {4'd0, {30'd0, b_mag_ff} * {30'd0, b_mag_ff}};
         r_ff   <= '0;
         bit_ff <= 64'h4000_0000_0000_0000;
      end else if (cmd.sqrt_step) begin
         if (v_ff >= rb) begin
            v_ff <= v_ff - rb;
            r_ff <= (r_ff >> 1) + bit_ff;
         end else begin
            r_ff <= r_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   logic        esub;
   logic [24:0] eval, eround;
   logic [7:0]  ebyte;
   logic [7:0]  red_ff, green_ff, blue_ff;

   always_comb begin
      case (cmd.chan)
         2'd0:    esub = !a_neg_ff;
         2'd1:    esub = !b_neg_ff;
         default: esub = 1'b0;
      endcase
      eval   = esub ? ENC_MID - {1'b0, div_quot[23:0]} : ENC_MID + {1'b0, div_quot[23:0]};
      eround = eval + 25'd32768;
      ebyte  = (eround[24:16] > 9'd255) ? 8'd255 : eround[23:16];
   end

   always_ff @(posedge clock) begin
      if (cmd.enc_save) begin
         case (cmd.chan)
            2'd0:    red_ff   <= ebyte;
            2'd1:    green_ff <= ebyte;
            default: blue_ff  <= ebyte;
         endcase
      end
   end

   logic       rsp_valid_ff;
   logic [7:0] o_red_ff, o_green_ff, o_blue_ff, o_x_ff, o_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         o_red_ff   <= red_ff;
         o_green_ff <= green_ff;
         o_blue_ff  <= blue_ff;
         o_x_ff     <= px_ff;
         o_y_ff     <= py_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_normal_red   = o_red_ff;
   assign rsp_normal_green = o_green_ff;
   assign rsp_normal_blue  = o_blue_ff;
   assign rsp_out_x        = o_x_ff;
   assign rsp_out_y        = o_y_ff;

   assign status.div_done = div_done;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

endmodule

`default_nettype wire
